[sv/asob_pkg.sv]
// Shared types, constants and helper functions for the ARGB source-over blender.
// Depends on nothing; imported by argb_source_over_blend.
package asob_pkg;

	localparam int unsigned CH_W    = 8;   // bits per channel
	localparam int unsigned NUM_CH  = 3;   // color channels: blue, green, red
	localparam int unsigned PIX_W   = 32;  // one ARGB8888 pixel
	localparam int unsigned WGT_W   = 16;  // weights, up to 255 * 255
	localparam int unsigned NUM_W   = 24;  // weighted channel sums plus rounding half
	localparam int unsigned ALPHA_LSB = 24;

	localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

	typedef enum logic [1:0] {
		MODE_PASS,     // top alpha is zero: bottom pixel goes through unchanged
		MODE_OPAQUE,   // bottom alpha is full: divide by 255 with the shift trick
		MODE_GENERAL   // general case: divide by the total weight
	} blend_mode_t;

	// One lane of the long divider: the partial remainder and the remaining
	// dividend bits, into which the quotient bits are shifted from the bottom.
	typedef struct packed {
		logic [WGT_W-1:0] rem;
		logic [CH_W-1:0]  low;
	} div_lane_t;

	function automatic logic [CH_W-1:0] chan(input logic [PIX_W-1:0] px,
			input int unsigned idx);
		return px[idx*CH_W +: CH_W];
	endfunction

	// Two restoring division steps. The remainder always stays below the
	// divisor, so the trial value needs only one extra bit.
	function automatic div_lane_t div_step2(input div_lane_t lane_in,
			input logic [WGT_W-1:0] divisor);
		div_lane_t      lane;
		logic [WGT_W:0] trial;
		lane = lane_in;
		for (int unsigned k = 0; k < 2; k++) begin
			trial = {lane.rem, lane.low[CH_W-1]};
			if (trial >= {1'b0, divisor}) begin
				lane.rem = WGT_W'(trial - {1'b0, divisor});
				lane.low = {lane.low[CH_W-2:0], 1'b1};
			end else begin
				lane.rem = trial[WGT_W-1:0];
				lane.low = {lane.low[CH_W-2:0], 1'b0};
			end
		end
		return lane;
	endfunction

endpackage

[sv/argb_source_over_blend.sv]
// Source-over compositing of two ARGB8888 pixels, seven stages deep.
// Depends on asob_pkg for channel widths, the blend mode type and the divider step.
//
//   Channel   Handshake               Payload
//   request   req_valid / req_ready   bottom_pixel[31:0], top_pixel[31:0]
//   response  rsp_valid / rsp_ready   blended_pixel[31:0]
//
// A word is loaded into stage 1 at the edge that accepts it and passes through stages 2
// to 7, the last being the response register. Unless the response stalls, a new word
// may enter in every cycle, so the sustained rate is one pixel per clock.
// The depth is set by the weight and product stages (two), one stage that rounds the
// simple cases and seeds the divider, and the long divider that produces two quotient
// bits per stage (four stages).
// Reset clears only the valid bits; the data registers need no reset.
// Each stage holds while the one after it is full and stalled, and takes new data as
// soon as it is empty, so bubbles close up and a stall neither drops nor repeats a word.
module argb_source_over_blend (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [asob_pkg::PIX_W-1:0]  bottom_pixel,
	input  logic [asob_pkg::PIX_W-1:0]  top_pixel,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [asob_pkg::PIX_W-1:0]  blended_pixel
);
	import asob_pkg::*;

	// Stage valid bits and load enables. A stage loads when it is empty or when
	// the stage after it is loading as well.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;

	assign en_s7 = !vld_s7 || rsp_ready;
	assign en_s6 = !vld_s6 || en_s7;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;

	assign req_ready = en_s1;
	assign rsp_valid = vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= req_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: pick the blend mode and form the two alpha weights.
	// The top weight is 255 * top alpha, done as a shift and a subtract;
	// the bottom weight is bottom alpha times the inverse top alpha.
	// ------------------------------------------------------------------
	logic [CH_W-1:0]  ta_c, ba_c, ia_c;
	logic [WGT_W-1:0] tw_c, bw_c;
	blend_mode_t      mode_c;

	always_comb begin
		ta_c = top_pixel[ALPHA_LSB +: CH_W];
		ba_c = bottom_pixel[ALPHA_LSB +: CH_W];
		ia_c = CH_MAX - ta_c;
		tw_c = {ta_c, {CH_W{1'b0}}} - WGT_W'(ta_c);
		bw_c = WGT_W'(ba_c) * WGT_W'(ia_c);
		if (ta_c == '0) begin
			mode_c = MODE_PASS;
		end else if (ba_c == CH_MAX) begin
			mode_c = MODE_OPAQUE;
		end else begin
			mode_c = MODE_GENERAL;
		end
	end

	logic [PIX_W-1:0] bot_s1, top_s1;
	logic [WGT_W-1:0] tw_s1, bw_s1;
	logic [CH_W-1:0]  ia_s1;
	blend_mode_t      mode_s1;

	always_ff @(posedge clk) begin
		if (en_s1 && req_valid) begin
			bot_s1  <= bottom_pixel;
			top_s1  <= top_pixel;
			tw_s1   <= tw_c;
			bw_s1   <= bw_c;
			ia_s1   <= ia_c;
			mode_s1 <= mode_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: per-channel products. The general path needs color times
	// weight for both pixels; the opaque-bottom path needs color times
	// alpha, which is a small 8 by 8 product pair.
	// ------------------------------------------------------------------
	logic [NUM_W-1:0] pt_c [NUM_CH];
	logic [NUM_W-1:0] pb_c [NUM_CH];
	logic [WGT_W-1:0] xo_c [NUM_CH];
	logic [WGT_W-1:0] w_c;

	always_comb begin
		w_c = tw_s1 + bw_s1;
		for (int unsigned c = 0; c < NUM_CH; c++) begin
			pt_c[c] = NUM_W'(chan(top_s1, c)) * NUM_W'(tw_s1);
			pb_c[c] = NUM_W'(chan(bot_s1, c)) * NUM_W'(bw_s1);
			xo_c[c] = WGT_W'(chan(top_s1, c)) * WGT_W'(top_s1[ALPHA_LSB +: CH_W])
			        + WGT_W'(chan(bot_s1, c)) * WGT_W'(ia_s1);
		end
	end

	logic [NUM_W-1:0] pt_s2 [NUM_CH];
	logic [NUM_W-1:0] pb_s2 [NUM_CH];
	logic [WGT_W-1:0] xo_s2 [NUM_CH];
	logic [WGT_W-1:0] w_s2;
	logic [PIX_W-1:0] bot_s2;
	blend_mode_t      mode_s2;

	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			pt_s2   <= pt_c;
			pb_s2   <= pb_c;
			xo_s2   <= xo_c;
			w_s2    <= w_c;
			bot_s2  <= bot_s1;
			mode_s2 <= mode_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: finish everything that does not need the divider.
	// The opaque-bottom channels are rounded as v = x + 128, then
	// (v + (v >> 8)) >> 8. The general alpha is (w + 127) / 255, done as
	// (n + (n >> 8) + 1) >> 8, which is exact for n below 255 * 256.
	// The general dividend is the weighted sum plus half the weight; since
	// the quotient is below 256, its upper bits already form a remainder
	// smaller than the weight and seed the divider directly.
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] fixed_c;
	div_lane_t        lane_c [NUM_CH];
	logic [NUM_W-1:0] num_c;
	logic [WGT_W:0]   rv_c, an_c, aq_c;

	always_comb begin
		rv_c = '0;
		an_c = (WGT_W+1)'(w_s2) + (WGT_W+1)'(CH_MAX >> 1);
		aq_c = an_c + (an_c >> CH_W) + (WGT_W+1)'(1);
		fixed_c = {aq_c[CH_W +: CH_W], {(PIX_W-CH_W){1'b0}}};
		for (int unsigned c = 0; c < NUM_CH; c++) begin
			num_c = pt_s2[c] + pb_s2[c] + NUM_W'(w_s2 >> 1);
			lane_c[c].rem = num_c[CH_W +: WGT_W];
			lane_c[c].low = num_c[CH_W-1:0];
		end
		case (mode_s2)
			MODE_PASS: begin
				fixed_c = bot_s2;
			end
			MODE_OPAQUE: begin
				fixed_c[ALPHA_LSB +: CH_W] = CH_MAX;
				for (int unsigned c = 0; c < NUM_CH; c++) begin
					rv_c = (WGT_W+1)'(xo_s2[c]) + (WGT_W+1)'(1 << (CH_W-1));
					rv_c = rv_c + (rv_c >> CH_W);
					fixed_c[c*CH_W +: CH_W] = rv_c[CH_W +: CH_W];
				end
			end
			default: begin
				// General case: alpha is set above, colors come from the divider.
			end
		endcase
	end

	div_lane_t        lane_s3 [NUM_CH];
	logic [WGT_W-1:0] w_s3;
	logic [PIX_W-1:0] fixed_s3;
	logic             general_s3;

	always_ff @(posedge clk) begin
		if (en_s3 && vld_s2) begin
			lane_s3    <= lane_c;
			w_s3       <= w_s2;
			fixed_s3   <= fixed_c;
			general_s3 <= (mode_s2 == MODE_GENERAL);
		end
	end

	// ------------------------------------------------------------------
	// Stages 4 to 7: the long divider, two quotient bits per stage for all
	// three channels at once. After the last stage each lane's low byte is
	// the rounded channel value.
	// ------------------------------------------------------------------
	div_lane_t        lane_s4 [NUM_CH];
	div_lane_t        lane_s5 [NUM_CH];
	div_lane_t        lane_s6 [NUM_CH];
	div_lane_t        lane_s7 [NUM_CH];
	logic [WGT_W-1:0] w_s4, w_s5, w_s6;
	logic [PIX_W-1:0] fixed_s4, fixed_s5, fixed_s6, fixed_s7;
	logic             general_s4, general_s5, general_s6, general_s7;

	always_ff @(posedge clk) begin
		if (en_s4 && vld_s3) begin
			for (int unsigned c = 0; c < NUM_CH; c++) begin
				lane_s4[c] <= div_step2(lane_s3[c], w_s3);
			end
			w_s4       <= w_s3;
			fixed_s4   <= fixed_s3;
			general_s4 <= general_s3;
		end
		if (en_s5 && vld_s4) begin
			for (int unsigned c = 0; c < NUM_CH; c++) begin
				lane_s5[c] <= div_step2(lane_s4[c], w_s4);
			end
			w_s5       <= w_s4;
			fixed_s5   <= fixed_s4;
			general_s5 <= general_s4;
		end
		if (en_s6 && vld_s5) begin
			for (int unsigned c = 0; c < NUM_CH; c++) begin
				lane_s6[c] <= div_step2(lane_s5[c], w_s5);
			end
			w_s6       <= w_s5;
			fixed_s6   <= fixed_s5;
			general_s6 <= general_s5;
		end
		if (en_s7 && vld_s6) begin
			for (int unsigned c = 0; c < NUM_CH; c++) begin
				lane_s7[c] <= div_step2(lane_s6[c], w_s6);
			end
			fixed_s7   <= fixed_s6;
			general_s7 <= general_s6;
		end
	end

	// The response register is stage 7. In the general case the alpha byte
	// was fixed in stage 3 and the colors are the quotients.
	always_comb begin
		blended_pixel = fixed_s7;
		if (general_s7) begin
			for (int unsigned c = 0; c < NUM_CH; c++) begin
				blended_pixel[c*CH_W +: CH_W] = lane_s7[c].low;
			end
		end
	end

endmodule
